>>> hdl/sti_pkg.sv
`default_nettype none

package sti_pkg;

    // field widths
    localparam int TIME_W     = 11;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int INT_W      = 24;
    localparam int ANG_W      = 16;
    localparam int FACT_W     = 24;
    localparam int OUT_INT_W  = 32;
    localparam int OUT_ANG_W  = 18;
    localparam int OPCODE_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int PROD_W     = INT_W + FACT_W;

    // divider widths: |dv| (INT_W bits) times dt (TIME_W bits) over a key span
    localparam int DIV_NUM_W  = INT_W + TIME_W;
    localparam int DIV_DEN_W  = TIME_W;

    localparam int DEFAULT_TABLE_DEPTH = 32;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ANSWERED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STORED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd3;

    // time and angle constants
    localparam logic [HOUR_W-1:0]   HOUR_MAX     = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX   = 6'd59;
    localparam logic [TIME_W-1:0]   NOON_MINUTES = 11'd720;
    localparam logic [OUT_ANG_W-1:0] ANGLE_NINETY = 18'd23040;
    localparam logic [OUT_INT_W-1:0] UNIT_Q16_16  = 32'd65536;
    localparam logic [FACT_W-1:0]   FACTOR_RESET = 24'd131;

    // one breakpoint of the table
    typedef struct packed {
        logic [TIME_W-1:0] key;
        logic [INT_W-1:0]  intensity;
        logic [ANG_W-1:0]  angle;
    } entry_t;

endpackage

`default_nettype wire

>>> hdl/sti_entry_ram.sv
`default_nettype none

module sti_entry_ram #(
    parameter int DEPTH = sti_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire sti_pkg::entry_t            wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output sti_pkg::entry_t                 rd_data
);
    import sti_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hdl/sti_divider.sv
`default_nettype none

module sti_divider (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [sti_pkg::DIV_NUM_W-1:0] numer,
    input  wire logic [sti_pkg::DIV_DEN_W-1:0] denom,
    output logic                               done,
    output logic [sti_pkg::DIV_NUM_W-1:0]      quot
);
    import sti_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_NUM_W-1:0] work_reg;

    logic [DIV_DEN_W:0]   shift_w;
    logic                 fits_w;
    logic [DIV_DEN_W:0]   diff_w;

    // one restoring step: bring down the next numerator bit, try to subtract
    always_comb begin
        shift_w = {rem_reg, work_reg[DIV_NUM_W-1]};
        diff_w  = shift_w - {1'b0, den_reg};
        fits_w  = (shift_w >= {1'b0, den_reg});
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // done pulses for one cycle after the last step
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(DIV_NUM_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath: quotient bits shift in where numerator bits leave
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            den_reg  <= denom;
            work_reg <= numer;
        end else if (busy_reg) begin
            rem_reg  <= fits_w ? diff_w[DIV_DEN_W-1:0] : shift_w[DIV_DEN_W-1:0];
            work_reg <= {work_reg[DIV_NUM_W-2:0], fits_w};
        end
    end

    assign done = done_reg;
    assign quot = work_reg;

endmodule

`default_nettype wire

>>> hdl/sun_table_interpolator.sv
`default_nettype none

// Channel  Direction  Ports                                           Moves
// -------  ---------  ----------------------------------------------  ---------------------
// cfg      in         cfg_valid, cfg_ready, cfg_data                  intensity factor word
// s_       in         s_valid, s_ready, s_opcode .. s_entry_angle     command word
// m_       out        m_valid, m_ready, m_status, m_intensity_out,    result word
//                     m_angle_out
//
// Clear and append go straight from idle to the output state, as does a query hitting the
// empty table; otherwise a query scans the table one entry at a time (registered table read),
// and when it interpolates it makes two passes through one shared 35-step restoring divider,
// one for intensity and one for angle.
// Reset (aresetn, synchronous) empties the table and loads the factor with its default.
// s_ready is high only between commands; a finished word waits in the output register
// while m_ready is low, and the next command may be accepted meanwhile.

module sun_table_interpolator #(
    parameter int TABLE_DEPTH = sti_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sti_pkg::FACT_W-1:0]        cfg_data,
    // command channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [sti_pkg::OPCODE_W-1:0]      s_opcode,
    input  wire logic [sti_pkg::HOUR_W-1:0]        s_hour,
    input  wire logic [sti_pkg::MINUTE_W-1:0]      s_minute,
    input  wire logic [sti_pkg::TIME_W-1:0]        s_entry_time,
    input  wire logic [sti_pkg::INT_W-1:0]         s_entry_intensity,
    input  wire logic [sti_pkg::ANG_W-1:0]         s_entry_angle,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [sti_pkg::STATUS_W-1:0]           m_status,
    output logic [sti_pkg::OUT_INT_W-1:0]          m_intensity_out,
    output logic signed [sti_pkg::OUT_ANG_W-1:0]   m_angle_out
);
    import sti_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WAIT,
        S_CHECK,
        S_MUL,
        S_START,
        S_DIV,
        S_SCALE,
        S_FINISH,
        S_OUT
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [TIME_W-1:0]     last_key_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  phase_reg;
    logic [FACT_W-1:0]     factor_reg;
    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [OUT_INT_W-1:0]  m_int_reg;
    logic [OUT_ANG_W-1:0]  m_ang_reg;

    // datapath registers
    logic [TIME_W-1:0]     t_reg;
    entry_t                prev_reg;
    entry_t                cur_reg;
    logic [DIV_NUM_W-1:0]  num_reg;
    logic [DIV_DEN_W-1:0]  den_reg;
    logic                  neg_reg;
    logic [INT_W-1:0]      res_int_reg;
    logic [ANG_W-1:0]      res_ang_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [STATUS_W-1:0]   pend_status_reg;
    logic [OUT_INT_W-1:0]  pend_int_reg;
    logic [OUT_ANG_W-1:0]  pend_ang_reg;

    logic                  s_fire;
    logic                  is_clear;
    logic                  is_append;
    logic                  table_full;
    logic                  app_reject;
    logic                  wr_en;
    entry_t                wr_data;
    entry_t                rd_data;
    logic [HOUR_W-1:0]     hour_c;
    logic [MINUTE_W-1:0]   minute_c;
    logic [TIME_W-1:0]     t_w;
    logic                  t_before;
    logic                  at_last;

    logic [INT_W-1:0]      v0_w;
    logic [INT_W-1:0]      v1_w;
    logic [INT_W:0]        diff_w;
    logic [INT_W:0]        diff_neg_w;
    logic [INT_W-1:0]      mag_w;
    logic [TIME_W-1:0]     dt_w;
    logic [DIV_NUM_W-1:0]  mul_w;
    logic                  div_start;
    logic                  div_done;
    logic [DIV_NUM_W-1:0]  div_quot;
    logic [INT_W-1:0]      q_w;
    logic [INT_W-1:0]      interp_w;
    logic [OUT_INT_W-1:0]  sat_w;
    logic [OUT_ANG_W-1:0]  fold_w;
    logic                  out_free;

    // command decode
    assign s_ready    = (state_reg == S_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign is_clear   = (s_opcode == OP_CLEAR);
    assign is_append  = (s_opcode == OP_APPEND);
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign app_reject = table_full || ((count_reg != '0) && (s_entry_time <= last_key_reg));
    assign wr_en      = s_fire && is_append && !app_reject;
    assign wr_data    = '{key: s_entry_time, intensity: s_entry_intensity,
                          angle: s_entry_angle};

    // time of day in minutes: h*60 = h*64 - h*4
    assign hour_c   = (s_hour > HOUR_MAX) ? HOUR_MAX : s_hour;
    assign minute_c = (s_minute > MINUTE_MAX) ? MINUTE_MAX : s_minute;
    assign t_w      = {hour_c, 6'b0} - {4'b0, hour_c, 2'b0} + {5'b0, minute_c};

    // scan compare
    assign t_before = (t_reg < rd_data.key);
    assign at_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // interpolation operands, intensity on phase 0 and angle on phase 1
    always_comb begin
        v0_w       = phase_reg ? INT_W'(prev_reg.angle) : prev_reg.intensity;
        v1_w       = phase_reg ? INT_W'(cur_reg.angle)  : cur_reg.intensity;
        diff_w     = {1'b0, v1_w} - {1'b0, v0_w};
        diff_neg_w = '0 - diff_w;
        mag_w      = diff_w[INT_W] ? diff_neg_w[INT_W-1:0] : diff_w[INT_W-1:0];
        dt_w       = t_reg - prev_reg.key;
        mul_w      = DIV_NUM_W'(mag_w) * DIV_NUM_W'(dt_w);
        q_w        = div_quot[INT_W-1:0];
        interp_w   = neg_reg ? (v0_w - q_w) : (v0_w + q_w);
    end

    // saturation and angle fold
    assign sat_w  = (prod_reg[PROD_W-1:OUT_INT_W+8] != '0) ? '1 : prod_reg[OUT_INT_W+7:8];
    assign fold_w = (t_reg > NOON_MINUTES) ? (ANGLE_NINETY - OUT_ANG_W'(res_ang_reg))
                                           : (ANGLE_NINETY + OUT_ANG_W'(res_ang_reg));

    assign div_start = (state_reg == S_START);
    assign out_free  = !m_valid_reg || m_ready;

    sti_entry_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    sti_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (num_reg),
        .denom   (den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // sequencer, table bookkeeping and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            phase_reg   <= 1'b0;
            factor_reg  <= FACTOR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                factor_reg <= cfg_data;
            end
            // S_OUT reloads the output register itself
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        if (is_clear) begin
                            count_reg <= '0;
                            state_reg <= S_OUT;
                        end else if (is_append) begin
                            if (!app_reject) begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                            state_reg <= S_OUT;
                        end else if (count_reg == '0) begin
                            state_reg <= S_OUT;
                        end else begin
                            idx_reg   <= '0;
                            state_reg <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    if (t_before && (idx_reg == '0)) begin
                        state_reg <= S_SCALE;
                    end else if (t_before) begin
                        phase_reg <= 1'b0;
                        state_reg <= S_MUL;
                    end else if (at_last) begin
                        state_reg <= S_SCALE;
                    end else begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= S_WAIT;
                    end
                end
                S_MUL: begin
                    state_reg <= S_START;
                end
                S_START: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (phase_reg) begin
                            state_reg <= S_SCALE;
                        end else begin
                            phase_reg <= 1'b1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_SCALE: begin
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= pend_status_reg;
                        m_int_reg    <= pend_int_reg;
                        m_ang_reg    <= pend_ang_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // last stored key, for the ascending-order check
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            last_key_reg <= s_entry_time;
        end
    end

    // query datapath
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            t_reg <= t_w;
            if (is_clear) begin
                pend_status_reg <= ST_CLEARED;
                pend_int_reg    <= '0;
                pend_ang_reg    <= '0;
            end else if (is_append) begin
                pend_status_reg <= app_reject ? ST_REJECTED : ST_STORED;
                pend_int_reg    <= '0;
                pend_ang_reg    <= '0;
            end else begin
                // empty table answer; overwritten when the scan runs
                pend_status_reg <= ST_ANSWERED;
                pend_int_reg    <= UNIT_Q16_16;
                pend_ang_reg    <= ANGLE_NINETY;
            end
        end
        if (state_reg == S_CHECK) begin
            if (t_before && (idx_reg != '0)) begin
                cur_reg <= rd_data;
            end else if (!t_before) begin
                prev_reg <= rd_data;
            end
            if (t_before ? (idx_reg == '0) : at_last) begin
                res_int_reg <= rd_data.intensity;
                res_ang_reg <= rd_data.angle;
            end
        end
        if (state_reg == S_MUL) begin
            num_reg <= mul_w;
            den_reg <= cur_reg.key - prev_reg.key;
            neg_reg <= diff_w[INT_W];
        end
        if ((state_reg == S_DIV) && div_done) begin
            if (phase_reg) begin
                res_ang_reg <= interp_w[ANG_W-1:0];
            end else begin
                res_int_reg <= interp_w;
            end
        end
        if (state_reg == S_SCALE) begin
            prod_reg <= PROD_W'(res_int_reg) * PROD_W'(factor_reg);
        end
        if (state_reg == S_FINISH) begin
            pend_int_reg <= sat_w;
            pend_ang_reg <= fold_w;
        end
    end

    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_intensity_out = m_int_reg;
    assign m_angle_out     = $signed(m_ang_reg);

endmodule

`default_nettype wire

>>> verif/sun_table_interpolator_tb.sv
`default_nettype none

module sun_table_interpolator_tb;

    import sti_pkg::*;

    localparam int      CLK_HALF       = 4;
    localparam int      CLK_PERIOD     = 2 * CLK_HALF;
    localparam int      DEPTH          = DEFAULT_TABLE_DEPTH;
    localparam int      PHASE_WORDS    = 180;
    localparam int      PHASE_COUNT    = 5;
    localparam int      HOLD_AFTER     = 400;
    localparam int      HOLD_CYCLES    = 600;
    localparam int      DRAIN_CYCLES   = 200;
    localparam int      REPORT_LIMIT   = 10;
    localparam longint  TIMEOUT_CYCLES = 1_500_000;
    localparam int      KEY_TOP        = 2047;
    localparam int      ANGLE_TOP      = 46080;
    localparam int      DIRECTED_MAX   = 32;

    // opcode 3 has no name in the package: the top bit alone selects a query
    localparam logic [OPCODE_W-1:0] OP_QUERY_HI = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [TIME_W-1:0]   entry_time;
        logic [INT_W-1:0]    entry_intensity;
        logic [ANG_W-1:0]    entry_angle;
    } command_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OUT_INT_W-1:0] intensity;
        logic [OUT_ANG_W-1:0] angle;
    } result_t;

    typedef struct packed {
        command_t cmd;
        logic     typed;
        result_t  want;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [FACT_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic [OPCODE_W-1:0] s_opcode;
    logic [HOUR_W-1:0] s_hour;
    logic [MINUTE_W-1:0] s_minute;
    logic [TIME_W-1:0] s_entry_time;
    logic [INT_W-1:0] s_entry_intensity;
    logic [ANG_W-1:0] s_entry_angle;
    logic m_valid;
    logic m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [OUT_INT_W-1:0] m_intensity_out;
    logic signed [OUT_ANG_W-1:0] m_angle_out;

    // shadow of the breakpoint table and the factor register
    logic [TIME_W-1:0] tbl_key [DEPTH];
    logic [INT_W-1:0]  tbl_int [DEPTH];
    logic [ANG_W-1:0]  tbl_ang [DEPTH];
    int                tbl_count;
    logic [FACT_W-1:0] factor_q8_16;

    // newest expected word at the front, oldest at the back
    result_t pending_results [$];

    // directed stimulus table
    stim_row_t directed_rows [DIRECTED_MAX];
    int        n_directed;

    bit calm;
    int fail_count;
    int words_sent;
    int words_checked;
    int n_queries;
    int n_saturated;
    int n_rejected;
    int n_factors;

    sun_table_interpolator #(
        .TABLE_DEPTH       (DEPTH)
    ) i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_hour            (s_hour),
        .s_minute          (s_minute),
        .s_entry_time      (s_entry_time),
        .s_entry_intensity (s_entry_intensity),
        .s_entry_angle     (s_entry_angle),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_intensity_out   (m_intensity_out),
        .m_angle_out       (m_angle_out)
    );

    // clock
    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one; none in a calm phase
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_angle();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 16'hFFFF);
        end
        return $urandom_range(0, ANGLE_TOP);
    endfunction

    function automatic command_t make_cmd(logic [OPCODE_W-1:0] op, int hr, int mn, int et,
                                          int ei, int ea);
        command_t c;
        c.opcode          = op;
        c.hour            = hr[HOUR_W-1:0];
        c.minute          = mn[MINUTE_W-1:0];
        c.entry_time      = et[TIME_W-1:0];
        c.entry_intensity = ei[INT_W-1:0];
        c.entry_angle     = ea[ANG_W-1:0];
        return c;
    endfunction

    function automatic command_t random_query();
        logic [OPCODE_W-1:0] op;
        op = ($urandom_range(0, 3) == 0) ? OP_QUERY_HI : OP_QUERY;
        return make_cmd(op, $urandom_range(0, 31), $urandom_range(0, 63),
                        $urandom_range(0, KEY_TOP), $urandom_range(0, 24'hFFFFFF),
                        $urandom_range(0, 16'hFFFF));
    endfunction

    // directed row; the expected word is given only where it is obvious
    function automatic stim_row_t row(logic [OPCODE_W-1:0] op, int hr, int mn, int et, int ei,
                                      int ea, logic typed = 1'b0,
                                      logic [STATUS_W-1:0] st = ST_ANSWERED,
                                      logic [OUT_INT_W-1:0] io = '0,
                                      logic [OUT_ANG_W-1:0] ao = '0);
        stim_row_t r;
        r.cmd            = make_cmd(op, hr, mn, et, ei, ea);
        r.typed          = typed;
        r.want.status    = st;
        r.want.intensity = io;
        r.want.angle     = ao;
        return r;
    endfunction

    // append one row to the directed table
    function automatic void add_row(stim_row_t r);
        directed_rows[n_directed] = r;
        n_directed++;
    endfunction

    // straight line between two breakpoints, division truncated toward zero
    function automatic longint blend(longint v0, longint v1, longint k0, longint k1,
                                     longint tt);
        return v0 + ((v1 - v0) * (tt - k0)) / (k1 - k0);
    endfunction

    // predicted result word for one command, updating the shadow table
    function automatic result_t sun_response(command_t c);
        result_t     r;
        int unsigned h;
        int unsigned m;
        int unsigned t;
        int          i;
        bit          found;
        longint      inten;
        longint      ang;
        longint      scaled;
        longint      folded;

        r = '0;
        if (c.opcode[1]) begin
            n_queries++;
            r.status = ST_ANSWERED;
            h = 32'((c.hour > HOUR_MAX) ? HOUR_MAX : c.hour);
            m = 32'((c.minute > MINUTE_MAX) ? MINUTE_MAX : c.minute);
            t = h * 60 + m;
            if (tbl_count == 0) begin
                r.intensity = UNIT_Q16_16;
                r.angle     = ANGLE_NINETY;
            end else begin
                if (t < tbl_key[0]) begin
                    inten = longint'(tbl_int[0]);
                    ang   = longint'(tbl_ang[0]);
                end else begin
                    inten = longint'(tbl_int[tbl_count-1]);
                    ang   = longint'(tbl_ang[tbl_count-1]);
                    found = 1'b0;
                    for (i = 1; i < tbl_count && !found; i++) begin
                        if (t < tbl_key[i]) begin
                            inten = blend(longint'(tbl_int[i-1]), longint'(tbl_int[i]),
                                          longint'(tbl_key[i-1]), longint'(tbl_key[i]),
                                          longint'(t));
                            ang   = blend(longint'(tbl_ang[i-1]), longint'(tbl_ang[i]),
                                          longint'(tbl_key[i-1]), longint'(tbl_key[i]),
                                          longint'(t));
                            found = 1'b1;
                        end
                    end
                end
                if (inten < 0) begin
                    inten = 0;
                end
                scaled = (inten * longint'(factor_q8_16)) >>> 8;
                if (scaled > 64'h0_FFFF_FFFF) begin
                    scaled = 64'h0_FFFF_FFFF;
                    n_saturated++;
                end
                r.intensity = scaled[OUT_INT_W-1:0];
                folded = (t > NOON_MINUTES) ? (longint'(ANGLE_NINETY) - ang)
                                            : (longint'(ANGLE_NINETY) + ang);
                r.angle = folded[OUT_ANG_W-1:0];
            end
        end else if (c.opcode == OP_CLEAR) begin
            tbl_count = 0;
            r.status  = ST_CLEARED;
        end else if (tbl_count >= DEPTH ||
                     (tbl_count > 0 && c.entry_time <= tbl_key[tbl_count-1])) begin
            n_rejected++;
            r.status = ST_REJECTED;
        end else begin
            tbl_key[tbl_count] = c.entry_time;
            tbl_int[tbl_count] = c.entry_intensity;
            tbl_ang[tbl_count] = c.entry_angle;
            tbl_count++;
            r.status = ST_STORED;
        end
        return r;
    endfunction

    // present one command word, wait for it to be taken, queue its result
    task automatic offer_word(command_t c, logic typed = 1'b0, result_t want = '0);
        int      gap;
        result_t predicted;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid           <= 1'b1;
        s_opcode          <= c.opcode;
        s_hour            <= c.hour;
        s_minute          <= c.minute;
        s_entry_time      <= c.entry_time;
        s_entry_intensity <= c.entry_intensity;
        s_entry_angle     <= c.entry_angle;
        do @(posedge aclk); while (!s_ready);
        predicted = sun_response(c);
        pending_results.push_front(typed ? want : predicted);
        words_sent++;
    endtask

    // stop offering and let every outstanding result drain
    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // factor write, only ever issued while the block is idle
    task automatic write_factor(logic [FACT_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        factor_q8_16 = value;
        n_factors++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // command stimulus
    initial begin : command_source
        logic [FACT_W-1:0] phase_factor [PHASE_COUNT];
        int                p;
        int                d;
        int                k;
        int                n;
        int                q;
        int                key;
        int                step_max;
        int                pick;
        int                sent_in_phase;
        bit                fill;

        aresetn           = 1'b0;
        cfg_valid         = 1'b0;
        cfg_data          = '0;
        s_valid           = 1'b0;
        s_opcode          = OP_CLEAR;
        s_hour            = '0;
        s_minute          = '0;
        s_entry_time      = '0;
        s_entry_intensity = '0;
        s_entry_angle     = '0;
        calm              = 1'b0;
        tbl_count         = 0;
        n_directed        = 0;
        factor_q8_16      = FACTOR_RESET;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, key ordering, extremes, bracketing and clamping
        add_row(row(OP_QUERY, 0, 0, 0, 0, 0, 1, ST_ANSWERED, UNIT_Q16_16, ANGLE_NINETY));
        add_row(row(OP_QUERY_HI, 31, 63, 0, 0, 0, 1, ST_ANSWERED, UNIT_Q16_16,
                    ANGLE_NINETY));
        add_row(row(OP_CLEAR, 0, 0, 0, 0, 0, 1, ST_CLEARED));
        add_row(row(OP_APPEND, 0, 0, 0, 0, 0, 1, ST_STORED));
        add_row(row(OP_APPEND, 0, 0, 0, 5, 5, 1, ST_REJECTED));
        add_row(row(OP_APPEND, 0, 0, 720, 24'hFFFFFF, ANGLE_TOP, 1, ST_STORED));
        add_row(row(OP_APPEND, 0, 0, 1439, 256, 16'hFFFF, 1, ST_STORED));
        add_row(row(OP_APPEND, 31, 63, KEY_TOP, 24'h000400, 100, 1, ST_STORED));
        add_row(row(OP_APPEND, 0, 0, 100, 1, 1, 1, ST_REJECTED));
        add_row(row(OP_QUERY, 0, 0, 0, 0, 0, 1, ST_ANSWERED, 0, ANGLE_NINETY));
        add_row(row(OP_QUERY, 12, 0, 0, 0, 0));
        add_row(row(OP_QUERY_HI, 12, 1, 0, 0, 0));
        add_row(row(OP_QUERY, 31, 63, 0, 0, 0));
        add_row(row(OP_QUERY, 6, 30, 0, 0, 0));
        add_row(row(OP_QUERY, 23, 59, 0, 0, 0));
        add_row(row(OP_QUERY, 18, 20, 0, 0, 0));
        add_row(row(OP_CLEAR, 0, 0, 0, 0, 0, 1, ST_CLEARED));
        add_row(row(OP_QUERY, 12, 0, 0, 0, 0, 1, ST_ANSWERED, UNIT_Q16_16, ANGLE_NINETY));
        add_row(row(OP_APPEND, 0, 0, 600, 24'h123456, 16'h5A5A, 1, ST_STORED));
        add_row(row(OP_QUERY, 5, 0, 0, 0, 0));
        add_row(row(OP_QUERY, 20, 0, 0, 0, 0));
        add_row(row(OP_APPEND, 0, 0, 600, 7, 7, 1, ST_REJECTED));
        add_row(row(OP_APPEND, 0, 0, 601, 24'hEDCBA9, 16'hA5A5, 1, ST_STORED));
        add_row(row(OP_QUERY, 10, 63, 0, 0, 0));

        for (d = 0; d < n_directed; d++) begin
            offer_word(directed_rows[d].cmd, directed_rows[d].typed, directed_rows[d].want);
        end
        quiesce();

        // random phases, one factor setting each, extremes included
        phase_factor[0] = 24'hFFFFFF;
        phase_factor[1] = 24'h000000;
        phase_factor[2] = 24'h010000;
        phase_factor[3] = FACT_W'($urandom_range(0, 24'hFFFFFF));
        phase_factor[4] = FACTOR_RESET;

        for (p = 0; p < PHASE_COUNT; p++) begin
            write_factor(phase_factor[p]);
            calm          = (p == 2);
            sent_in_phase = 0;
            while (sent_in_phase < PHASE_WORDS) begin
                pick = $urandom_range(0, 9);
                if (pick < 7 || (p == 0 && sent_in_phase == 0)) begin
                    // well-formed load: clear, ascending appends, then queries
                    fill     = (p == 0 && sent_in_phase == 0) || $urandom_range(0, 7) == 0;
                    n        = fill ? $urandom_range(DEPTH - 1, DEPTH + 2) : $urandom_range(1, 6);
                    step_max = fill ? 40 : 240;
                    key      = $urandom_range(0, 60);
                    offer_word(make_cmd(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 63),
                                        $urandom_range(0, KEY_TOP),
                                        $urandom_range(0, 24'hFFFFFF), pick_angle()));
                    for (k = 0; k < n; k++) begin
                        offer_word(make_cmd(OP_APPEND, $urandom_range(0, 31),
                                            $urandom_range(0, 63), key,
                                            $urandom_range(0, 24'hFFFFFF), pick_angle()));
                        key = key + $urandom_range(1, step_max);
                        if (key > KEY_TOP) begin
                            key = KEY_TOP;
                        end
                    end
                    q = $urandom_range(2, 8);
                    for (k = 0; k < q; k++) begin
                        offer_word(random_query());
                    end
                    sent_in_phase += 1 + n + q;
                end else if (pick == 7) begin
                    // noise: any opcode, any field
                    offer_word(make_cmd(OPCODE_W'($urandom_range(0, 3)), $urandom_range(0, 31),
                                        $urandom_range(0, 63), $urandom_range(0, KEY_TOP),
                                        $urandom_range(0, 24'hFFFFFF),
                                        $urandom_range(0, 16'hFFFF)));
                    sent_in_phase++;
                end else if (pick == 8) begin
                    // broken load: key not above the last one stored
                    key = (tbl_count > 0) ? $urandom_range(0, tbl_key[tbl_count-1])
                                          : $urandom_range(0, KEY_TOP);
                    offer_word(make_cmd(OP_APPEND, 0, 0, key, $urandom_range(0, 24'hFFFFFF),
                                        pick_angle()));
                    sent_in_phase++;
                end else begin
                    offer_word(random_query());
                    sent_in_phase++;
                end
            end
            quiesce();
        end

        calm = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d command words, %0d result words, %0d factor settings",
                 words_sent, words_checked, n_factors);
        $display("queries %0d (saturated %0d), rejected appends %0d, mismatches %0d",
                 n_queries, n_saturated, n_rejected, fail_count);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("PASS sun_table_interpolator");
        end else begin
            $display("FAIL sun_table_interpolator");
        end
        $finish;
    end

    // result sink: random back-pressure plus one long hold-off
    initial begin : result_sink
        int      gap_left;
        int      hold_left;
        bit      hold_done;
        result_t got;
        result_t want;

        gap_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                if (gap_left == 0 && $urandom_range(0, 3) == 0) begin
                    gap_left = pick_gap();
                end
                if (gap_left > 0) begin
                    m_ready <= 1'b0;
                    gap_left--;
                end else begin
                    m_ready <= 1'b1;
                end
            end
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = {m_status, m_intensity_out, m_angle_out};
                words_checked++;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("unexpected result word: status %0d intensity %h angle %h",
                                 got.status, got.intensity, got.angle);
                    end
                end else begin
                    want = pending_results.pop_back();
                    if (got.status != want.status || got.intensity != want.intensity ||
                        got.angle != want.angle) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("result word %0d: status %0d/%0d intensity %h/%h angle %h/%h",
                                     words_checked, want.status, got.status, want.intensity,
                                     got.intensity, want.angle, got.angle);
                        end
                    end
                end
                // long stall so the block backs up and holds off its input
                if (words_checked == HOLD_AFTER && !hold_done) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
        end
    end

    // watchdog
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timed out with %0d result words outstanding", pending_results.size());
        $display("FAIL sun_table_interpolator");
        $finish;
    end

endmodule

`default_nettype wire
